// ===== rtl/core/owm_pkg.sv =====
// Package for the 1-wire bus master: command codes, register indexes,
// register reset values and the reflected CRC-8 fold.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

  // Command codes carried by the mode field
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_SMP  = 3'd1,
    REG_RESET_RECOVER = 3'd2,
    REG_SHORT_LOW     = 3'd3,
    REG_WR1_RECOVER   = 3'd4,
    REG_WR0_LOW       = 3'd5,
    REG_WR0_RECOVER   = 3'd6,
    REG_READ_SAMPLE   = 3'd7
  } reg_idx_e;

  localparam int unsigned TimeW    = 10;
  localparam int unsigned ShortW   = 8;
  localparam int unsigned CfgDataW = 10;

  localparam logic [TimeW-1:0]  ResetLowDefault     = 10'd480;
  localparam logic [TimeW-1:0]  PresenceSmpDefault  = 10'd70;
  localparam logic [TimeW-1:0]  ResetRecoverDefault = 10'd410;
  localparam logic [ShortW-1:0] ShortLowDefault     = 8'd6;
  localparam logic [ShortW-1:0] Wr1RecoverDefault   = 8'd64;
  localparam logic [ShortW-1:0] Wr0LowDefault       = 8'd60;
  localparam logic [ShortW-1:0] Wr0RecoverDefault   = 8'd10;
  localparam logic [ShortW-1:0] ReadSampleDefault   = 8'd9;

  // Released ticks after a read-bit sample
  localparam logic [ShortW-1:0] ReadRecoverUs = 8'd55;

  localparam logic [7:0] CrcPoly = 8'h8c;

  // Fold one byte into the reflected CRC-8
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/onewire_master_with_crc8.sv =====
// 1-wire bus master top level: per-tick slot timing FSM, CRC-8 over read bytes.
// Depends on owm_pkg.
// The result of an accepted tick transaction is registered, valid in the next cycle.
// Throughput: one tick per cycle; the single result register sets this and
// input stalls only while that register holds a result that is stalled.
// Reset: all control and timing state clear, registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none

module onewire_master_with_crc8 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [owm_pkg::CfgDataW-1:0]  cfg_data_i,
  // tick input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [7:0]                    write_data_i,
  input  wire logic                          bus_level_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               drive_low_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic                               presence_o,
  output logic [7:0]                         read_data_o,
  output logic                               crc_ok_o,
  output logic                               rejected_o
);
  import owm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_RST_LOW      = 3'd1,
    PH_RST_WAIT     = 3'd2,
    PH_RST_RECOVER  = 3'd3,
    PH_SLOT_LOW     = 3'd4,
    PH_SLOT_WAIT    = 3'd5,
    PH_READ_RECOVER = 3'd6
  } phase_e;

  // configuration registers
  logic [TimeW-1:0]  reset_low_q, presence_smp_q, reset_recover_q;
  logic [ShortW-1:0] short_low_q, wr1_recover_q, wr0_low_q, wr0_recover_q, read_sample_q;

  // bus state
  phase_e      phase_q, phase_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  crc_q, crc_d;
  logic        pres_q, pres_d;
  cmd_e        cmd_q, cmd_d;
  logic [7:0]  last_read_q, last_read_d;

  // result register
  logic        out_valid_q;
  logic        drive_q, busy_q, done_q, rej_q;
  logic        drive_d, busy_d, done_d, rej_d;

  logic        in_accept;
  logic        out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_accept  = in_valid_i && out_free;

  // Write a configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q     <= ResetLowDefault;
      presence_smp_q  <= PresenceSmpDefault;
      reset_recover_q <= ResetRecoverDefault;
      short_low_q     <= ShortLowDefault;
      wr1_recover_q   <= Wr1RecoverDefault;
      wr0_low_q       <= Wr0LowDefault;
      wr0_recover_q   <= Wr0RecoverDefault;
      read_sample_q   <= ReadSampleDefault;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_RESET_LOW:     reset_low_q     <= cfg_data_i[TimeW-1:0];
        REG_PRESENCE_SMP:  presence_smp_q  <= cfg_data_i[TimeW-1:0];
        REG_RESET_RECOVER: reset_recover_q <= cfg_data_i[TimeW-1:0];
        REG_SHORT_LOW:     short_low_q     <= cfg_data_i[ShortW-1:0];
        REG_WR1_RECOVER:   wr1_recover_q   <= cfg_data_i[ShortW-1:0];
        REG_WR0_LOW:       wr0_low_q       <= cfg_data_i[ShortW-1:0];
        REG_WR0_RECOVER:   wr0_recover_q   <= cfg_data_i[ShortW-1:0];
        REG_READ_SAMPLE:   read_sample_q   <= cfg_data_i[ShortW-1:0];
        default: ;
      endcase
    end
  end

  // Low time of the next slot: write-zero uses its own, else the short one
  function automatic logic [TimeW-1:0] slot_low(input cmd_e c, input logic lsb,
                                                input logic [ShortW-1:0] wr0,
                                                input logic [ShortW-1:0] shrt);
    logic [ShortW-1:0] t;
    t = (c == CMD_WRITE && !lsb) ? wr0 : shrt;
    return {{(TimeW-ShortW){1'b0}}, t};
  endfunction

  // Advance the bus FSM by one tick
  always_comb begin
    phase_d     = phase_q;
    time_d      = time_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    crc_d       = crc_q;
    pres_d      = pres_q;
    cmd_d       = cmd_q;
    last_read_d = last_read_q;
    rej_d       = 1'b0;
    done_d      = 1'b0;

    // start a command, or reject it while busy
    if (phase_q != PH_IDLE) begin
      rej_d = (cmd_e'(mode_i) != CMD_TICK);
    end else if (cmd_e'(mode_i) != CMD_TICK) begin
      cmd_d = cmd_e'(mode_i);
      bit_d = 3'd0;
      if (cmd_e'(mode_i) == CMD_RESET) begin
        crc_d   = 8'd0;
        phase_d = PH_RST_LOW;
        time_d  = reset_low_q;
      end else begin
        shift_d = (cmd_e'(mode_i) == CMD_WRITE) ? write_data_i : 8'd0;
        phase_d = PH_SLOT_LOW;
        time_d  = slot_low(cmd_e'(mode_i), shift_d[0], wr0_low_q, short_low_q);
      end
    end

    busy_d  = (phase_d != PH_IDLE);
    drive_d = (phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_LOW);

    // count down the phase, then move on at its last tick
    if (busy_d) begin
      if (time_d > TimeW'(1)) begin
        time_d = time_d - TimeW'(1);
      end else begin
        unique case (phase_d)
          PH_RST_LOW: begin
            phase_d = PH_RST_WAIT;
            time_d  = presence_smp_q;
          end
          PH_RST_WAIT: begin
            pres_d  = !bus_level_i;
            phase_d = PH_RST_RECOVER;
            time_d  = reset_recover_q;
          end
          PH_RST_RECOVER: begin
            phase_d = PH_IDLE;
            time_d  = '0;
            done_d  = 1'b1;
          end
          PH_SLOT_LOW: begin
            phase_d = PH_SLOT_WAIT;
            if (cmd_d == CMD_WRITE) begin
              time_d = {{(TimeW-ShortW){1'b0}}, shift_d[0] ? wr1_recover_q : wr0_recover_q};
            end else begin
              time_d = {{(TimeW-ShortW){1'b0}}, read_sample_q};
            end
          end
          PH_SLOT_WAIT, PH_READ_RECOVER: begin
            if (phase_d == PH_SLOT_WAIT && cmd_d != CMD_WRITE) begin
              // sample the read bit, LSB first
              shift_d = {bus_level_i, shift_d[7:1]};
              phase_d = PH_READ_RECOVER;
              time_d  = {{(TimeW-ShortW){1'b0}}, ReadRecoverUs};
            end else if (bit_d == 3'd7) begin
              // last bit: finish the byte
              phase_d = PH_IDLE;
              time_d  = '0;
              done_d  = 1'b1;
              if (cmd_d == CMD_READ) begin
                last_read_d = shift_d;
                crc_d       = crc8_fold(crc_d, shift_d);
              end
            end else begin
              bit_d = bit_d + 3'd1;
              if (cmd_d == CMD_WRITE) begin
                shift_d = shift_d >> 1;
              end
              phase_d = PH_SLOT_LOW;
              time_d  = slot_low(cmd_d, shift_d[0], wr0_low_q, short_low_q);
            end
          end
          default: begin
            phase_d = PH_IDLE;
            time_d  = '0;
          end
        endcase
      end
    end
  end

  // Hold bus state; update it on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      time_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      crc_q       <= '0;
      pres_q      <= 1'b0;
      cmd_q       <= CMD_TICK;
      last_read_q <= '0;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      time_q      <= time_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      crc_q       <= crc_d;
      pres_q      <= pres_d;
      cmd_q       <= cmd_d;
      last_read_q <= last_read_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_accept;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      drive_q <= drive_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      rej_q   <= rej_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = drive_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign rejected_o  = rej_q;
  assign presence_o  = pres_q;
  assign read_data_o = last_read_q;
  assign crc_ok_o    = (crc_q == 8'd0);

  // A finished or rejected tick always belongs to a running command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (done_q || rej_q) |-> busy_q)
    else $error("done or rejected without busy");

  // Driving low only happens inside a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && drive_q |-> busy_q && !done_q)
    else $error("bus driven outside a command");

  // An idle result leaves the FSM idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !busy_q |-> phase_q == PH_IDLE)
    else $error("idle result with FSM not idle");

  // A completed command returns the FSM to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> phase_q == PH_IDLE && time_q == '0)
    else $error("FSM not idle after done");

endmodule

`default_nettype wire
